FILE: design/mrtb_pkg.sv
// Shared types, codes and constants of the multi-resolution timer bank.
`default_nettype none
package mrtb_pkg;

    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_START  = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;
    localparam logic [2:0] OP_CHECK  = 3'd5;

    localparam logic [1:0] BANK_FAST = 2'd0;
    localparam logic [1:0] BANK_MID  = 2'd1;
    localparam logic [1:0] BANK_SLOW = 2'd2;
    localparam logic [1:0] BANK_NONE = 2'd3;

    localparam logic [1:0] CH_FREE = 2'd0;
    localparam logic [1:0] CH_STOP = 2'd1;
    localparam logic [1:0] CH_RUN  = 2'd2;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_MID    = 2'd1;
    localparam logic [1:0] REG_SLOW   = 2'd2;

    // Reciprocals for the interval divide: x/10 and x/100 are exact for 16-bit x.
    localparam logic [15:0] RECIP_10  = 16'd52429;
    localparam int          SHIFT_10  = 19;
    localparam logic [17:0] RECIP_100 = 18'd167773;
    localparam int          SHIFT_100 = 24;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  bank;
        logic        ch_ok;
        logic [7:0]  loc;
        logic [16:0] reload;
        logic        cyclic;
    } t_cmd;

    typedef struct packed {
        logic        last;
        logic [2:0]  ch;
        logic [6:0]  unit;
        logic        fired;
        logic        ok;
    } t_result;

    function automatic logic [6:0] bank_unit(input logic [1:0] bank);
        logic [6:0] u;
        case (bank)
            BANK_FAST: u = 7'd1;
            BANK_MID:  u = 7'd10;
            BANK_SLOW: u = 7'd100;
            default:   u = 7'd0;
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

FILE: design/multi_resolution_timer_bank.sv
// Top level: a multi-resolution timer bank with streaming input and result ports.
// Delete, start, stop and disabled operations pass the front register and the queue and are
// answered from idle into the result register. Create scans for a free channel; tick and enabled
// check sweep all FAST+MID+SLOW channels one per cycle, a check pausing while a result waits.
// A two-entry queue lets new beats enter while the execution unit is busy.
// Reset (synchronous, active low) frees every channel, clears the prescalers, loads defaults.
`default_nettype none
module multi_resolution_timer_bank #(
    parameter int FAST_CHANNELS = 8,
    parameter int MID_CHANNELS  = 8,
    parameter int SLOW_CHANNELS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [5:0]  i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // unit_ms[7:0], channel[15:8], interval_ms[31:16], cyclic[32], zeros above
    input  wire logic [39:0] i_s_tdata,
    // operation[2:0]
    input  wire logic [2:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // ok[0], fired[1], out_unit_ms[8:2], out_channel[11:9], zeros above
    output logic [15:0]      o_m_tdata,
    output logic             o_m_tlast
);

    logic              fr_valid;
    logic              q_ready;
    mrtb_pkg::t_cmd    fr_cmd;
    logic              q_valid;
    logic              q_pop;
    mrtb_pkg::t_cmd    q_cmd;
    mrtb_pkg::t_result res;

    mrtb_front #(
        .FAST_CHANNELS(FAST_CHANNELS),
        .MID_CHANNELS (MID_CHANNELS),
        .SLOW_CHANNELS(SLOW_CHANNELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_op         (i_s_tuser),
        .i_unit_ms    (i_s_tdata[7:0]),
        .i_channel    (i_s_tdata[15:8]),
        .i_interval_ms(i_s_tdata[31:16]),
        .i_cyclic     (i_s_tdata[32]),
        .o_valid      (fr_valid),
        .i_ready      (q_ready),
        .o_cmd        (fr_cmd)
    );

    mrtb_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (fr_valid),
        .o_ready(q_ready),
        .i_data (fr_cmd),
        .o_valid(q_valid),
        .i_pop  (q_pop),
        .o_data (q_cmd)
    );

    mrtb_back #(
        .FAST_CHANNELS(FAST_CHANNELS),
        .MID_CHANNELS (MID_CHANNELS),
        .SLOW_CHANNELS(SLOW_CHANNELS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd_valid(q_valid),
        .o_cmd_pop  (q_pop),
        .i_cmd      (q_cmd),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_res      (res)
    );

    assign o_m_tdata = {4'b0000, res.ch, res.unit, res.fired, res.ok};
    assign o_m_tlast = res.last;

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");

    a_fired_has_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1] |-> o_m_tdata[0] && (o_m_tdata[8:2] != 7'd0))
        else $error("expired channel result without ok or bank");

    a_not_last_is_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[1])
        else $error("non-final beat that is not an expired channel");

endmodule
`default_nettype wire

FILE: design/mrtb_front.sv
// Front end: decodes the bank, checks the channel and computes the reload value.
`default_nettype none
module mrtb_front #(
    parameter int FAST_CHANNELS = 8,
    parameter int MID_CHANNELS  = 8,
    parameter int SLOW_CHANNELS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [2:0]    i_op,
    input  wire logic [7:0]    i_unit_ms,
    input  wire logic [7:0]    i_channel,
    input  wire logic [15:0]   i_interval_ms,
    input  wire logic          i_cyclic,
    output logic               o_valid,
    input  wire logic          i_ready,
    output mrtb_pkg::t_cmd     o_cmd
);

    logic           r_valid;
    mrtb_pkg::t_cmd r_cmd;
    mrtb_pkg::t_cmd n_cmd;
    logic [1:0]     bank;
    logic [7:0]     size;
    logic [31:0]    prod10;
    logic [33:0]    prod100;
    logic [15:0]    quot;

    always_comb begin
        case (i_unit_ms)
            8'd1:    bank = mrtb_pkg::BANK_FAST;
            8'd10:   bank = mrtb_pkg::BANK_MID;
            8'd100:  bank = mrtb_pkg::BANK_SLOW;
            default: bank = mrtb_pkg::BANK_NONE;
        endcase
        case (bank)
            mrtb_pkg::BANK_FAST: size = 8'(FAST_CHANNELS);
            mrtb_pkg::BANK_MID:  size = 8'(MID_CHANNELS);
            mrtb_pkg::BANK_SLOW: size = 8'(SLOW_CHANNELS);
            default:             size = 8'd0;
        endcase
        prod10  = 32'(i_interval_ms) * 32'(mrtb_pkg::RECIP_10);
        prod100 = 34'(i_interval_ms) * 34'(mrtb_pkg::RECIP_100);
        case (bank)
            mrtb_pkg::BANK_MID:  quot = 16'(prod10 >> mrtb_pkg::SHIFT_10);
            mrtb_pkg::BANK_SLOW: quot = 16'(prod100 >> mrtb_pkg::SHIFT_100);
            default:             quot = i_interval_ms;
        endcase
        n_cmd.op     = i_op;
        n_cmd.bank   = bank;
        n_cmd.ch_ok  = (bank != mrtb_pkg::BANK_NONE) && (i_channel < size);
        n_cmd.loc    = i_channel;
        n_cmd.reload = 17'(quot) + 17'(!i_cyclic);
        n_cmd.cyclic = i_cyclic;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: design/mrtb_queue.sv
// Two-entry command queue between the front end and the execution unit.
`default_nettype none
module mrtb_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    output logic                o_ready,
    input  mrtb_pkg::t_cmd      i_data,
    output logic                o_valid,
    input  wire logic           i_pop,
    output mrtb_pkg::t_cmd      o_data
);

    mrtb_pkg::t_cmd r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push_ok;
    logic           pop_ok;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= !r_wp;
            end
            if (pop_ok) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: design/mrtb_back.sv
// Execution unit: channel state, create, tick and check scans, result register.
`default_nettype none
module mrtb_back #(
    parameter int FAST_CHANNELS = 8,
    parameter int MID_CHANNELS  = 8,
    parameter int SLOW_CHANNELS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [5:0]    i_cfg_data,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    input  mrtb_pkg::t_cmd     i_cmd,
    output logic               o_valid,
    input  wire logic          i_ready,
    output mrtb_pkg::t_result  o_res
);

    localparam int TOTAL = FAST_CHANNELS + MID_CHANNELS + SLOW_CHANNELS;
    localparam int IW    = $clog2(TOTAL);

    typedef enum logic [2:0] {S_IDLE, S_CREATE, S_TICK, S_CHECK, S_EMIT} t_state;

    t_state             r_state, n_state;
    logic [1:0]         r_bank, n_bank;
    logic [7:0]         r_loc, n_loc;
    logic [2:0]         r_sel, n_sel;
    logic               r_pend_v, n_pend_v;
    logic [6:0]         r_pend_unit, n_pend_unit;
    logic [2:0]         r_pend_ch, n_pend_ch;
    mrtb_pkg::t_result  r_res, n_res;
    mrtb_pkg::t_cmd     r_cmd, n_cmd;
    logic               r_enable;
    logic [5:0]         r_mid_div, r_slow_div;
    logic [5:0]         r_pre_mid, n_pre_mid;
    logic [5:0]         r_pre_slow, n_pre_slow;
    logic               r_o_valid;
    mrtb_pkg::t_result  r_o;

    logic [1:0]         r_status [TOTAL];
    logic [16:0]        r_count  [TOTAL];
    logic [16:0]        r_reload [TOTAL];
    logic               r_cyc    [TOTAL];

    logic [1:0]         cur_bank;
    logic [7:0]         cur_loc;
    logic [IW-1:0]      base;
    logic [IW-1:0]      flat;
    logic [7:0]         size_last;
    logic [7:0]         next_last;
    logic [1:0]         rd_status;
    logic [16:0]        rd_count;
    logic [16:0]        rd_reload;
    logic               rd_cyc;
    logic               slot;
    logic               emit;
    mrtb_pkg::t_result  res;
    logic               st_we;
    logic [1:0]         st_wdata;
    logic               cnt_we;
    logic [16:0]        cnt_wdata;
    logic               rl_we;
    logic               hit;
    logic               mid_hit, slow_hit;

    always_comb begin
        cur_bank = (r_state == S_IDLE) ? i_cmd.bank : r_bank;
        cur_loc  = (r_state == S_IDLE) ? i_cmd.loc : r_loc;
        case (cur_bank)
            mrtb_pkg::BANK_MID:  base = IW'(FAST_CHANNELS);
            mrtb_pkg::BANK_SLOW: base = IW'(FAST_CHANNELS + MID_CHANNELS);
            default:             base = '0;
        endcase
        flat = base + IW'(cur_loc);
        case (r_bank)
            mrtb_pkg::BANK_FAST: size_last = 8'(FAST_CHANNELS - 1);
            mrtb_pkg::BANK_MID:  size_last = 8'(MID_CHANNELS - 1);
            default:             size_last = 8'(SLOW_CHANNELS - 1);
        endcase
        next_last = (r_bank == mrtb_pkg::BANK_FAST) ? 8'(MID_CHANNELS - 1)
                                                    : 8'(SLOW_CHANNELS - 1);
    end

    assign rd_status = r_status[flat];
    assign rd_count  = r_count[flat];
    assign rd_reload = r_reload[flat];
    assign rd_cyc    = r_cyc[flat];
    assign slot      = !r_o_valid || i_ready;
    assign hit       = (rd_status == mrtb_pkg::CH_RUN) && (rd_count == 17'd0);
    assign mid_hit   = (7'(r_pre_mid) + 7'd1) >= 7'(r_mid_div);
    assign slow_hit  = (7'(r_pre_slow) + 7'd1) >= 7'(r_slow_div);

    always_comb begin
        n_state     = r_state;
        n_bank      = r_bank;
        n_loc       = r_loc;
        n_sel       = r_sel;
        n_pend_v    = r_pend_v;
        n_pend_unit = r_pend_unit;
        n_pend_ch   = r_pend_ch;
        n_res       = r_res;
        n_cmd       = r_cmd;
        n_pre_mid   = r_pre_mid;
        n_pre_slow  = r_pre_slow;
        o_cmd_pop   = 1'b0;
        emit        = 1'b0;
        res         = '0;
        res.last    = 1'b1;
        st_we       = 1'b0;
        st_wdata    = mrtb_pkg::CH_FREE;
        cnt_we      = 1'b0;
        cnt_wdata   = rd_reload;
        rl_we       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && slot) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_bank    = i_cmd.bank;
                    n_loc     = 8'd0;
                    case (i_cmd.op)
                        mrtb_pkg::OP_CREATE: begin
                            if (i_cmd.bank != mrtb_pkg::BANK_NONE) begin
                                n_state = S_CREATE;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        mrtb_pkg::OP_DELETE: begin
                            st_we  = i_cmd.ch_ok;
                            emit   = 1'b1;
                            res.ok = i_cmd.ch_ok;
                        end
                        mrtb_pkg::OP_START: begin
                            emit = 1'b1;
                            if (i_cmd.ch_ok && rd_status != mrtb_pkg::CH_FREE) begin
                                st_we    = 1'b1;
                                st_wdata = mrtb_pkg::CH_RUN;
                                cnt_we   = 1'b1;
                                res.ok   = 1'b1;
                            end
                        end
                        mrtb_pkg::OP_STOP: begin
                            emit = 1'b1;
                            if (i_cmd.ch_ok && rd_status != mrtb_pkg::CH_FREE) begin
                                st_we    = 1'b1;
                                st_wdata = mrtb_pkg::CH_STOP;
                                res.ok   = 1'b1;
                            end
                        end
                        mrtb_pkg::OP_TICK: begin
                            if (r_enable) begin
                                n_pre_mid  = mid_hit ? 6'd0 : r_pre_mid + 6'd1;
                                n_pre_slow = slow_hit ? 6'd0 : r_pre_slow + 6'd1;
                                n_sel      = {slow_hit, mid_hit, 1'b1};
                                n_bank     = mrtb_pkg::BANK_FAST;
                                n_res      = '0;
                                n_res.ok   = 1'b1;
                                n_res.last = 1'b1;
                                n_state    = S_TICK;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        mrtb_pkg::OP_CHECK: begin
                            if (r_enable) begin
                                n_bank   = mrtb_pkg::BANK_FAST;
                                n_loc    = 8'(FAST_CHANNELS - 1);
                                n_pend_v = 1'b0;
                                n_state  = S_CHECK;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_CREATE: begin
                if (slot) begin
                    if (rd_status == mrtb_pkg::CH_FREE) begin
                        st_we    = 1'b1;
                        st_wdata = mrtb_pkg::CH_STOP;
                        rl_we    = 1'b1;
                        emit     = 1'b1;
                        res.ok   = 1'b1;
                        res.unit = mrtb_pkg::bank_unit(r_bank);
                        res.ch   = r_loc[2:0];
                        n_state  = S_IDLE;
                    end else if (r_loc == size_last) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_loc = r_loc + 8'd1;
                    end
                end
            end
            S_TICK: begin
                if (r_sel[r_bank] && rd_status == mrtb_pkg::CH_RUN && rd_count != 17'd0) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = rd_count - 17'd1;
                end
                if (r_loc == size_last) begin
                    if (r_bank == mrtb_pkg::BANK_SLOW) begin
                        n_state = S_EMIT;
                    end else begin
                        n_bank = r_bank + 2'd1;
                        n_loc  = 8'd0;
                    end
                end else begin
                    n_loc = r_loc + 8'd1;
                end
            end
            S_CHECK: begin
                // A new hit pushes the held one out, so it waits for a free slot.
                if (!(hit && r_pend_v && !slot)) begin
                    if (hit) begin
                        cnt_we      = rd_cyc;
                        emit        = r_pend_v;
                        res.ok      = 1'b1;
                        res.fired   = 1'b1;
                        res.unit    = r_pend_unit;
                        res.ch      = r_pend_ch;
                        res.last    = 1'b0;
                        n_pend_v    = 1'b1;
                        n_pend_unit = mrtb_pkg::bank_unit(r_bank);
                        n_pend_ch   = r_loc[2:0];
                    end
                    if (r_loc == 8'd0) begin
                        if (r_bank == mrtb_pkg::BANK_SLOW) begin
                            n_res      = '0;
                            n_res.ok   = 1'b1;
                            n_res.last = 1'b1;
                            if (hit || r_pend_v) begin
                                n_res.fired = 1'b1;
                                n_res.unit  = n_pend_unit;
                                n_res.ch    = n_pend_ch;
                            end
                            n_state = S_EMIT;
                        end else begin
                            n_bank = r_bank + 2'd1;
                            n_loc  = next_last;
                        end
                    end else begin
                        n_loc = r_loc - 8'd1;
                    end
                end
            end
            S_EMIT: begin
                if (slot) begin
                    emit    = 1'b1;
                    res     = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_enable   <= 1'b1;
            r_mid_div  <= 6'd5;
            r_slow_div <= 6'd50;
            r_pre_mid  <= 6'd0;
            r_pre_slow <= 6'd0;
            r_pend_v   <= 1'b0;
            r_o_valid  <= 1'b0;
            for (int i = 0; i < TOTAL; i++) begin
                r_status[i] <= mrtb_pkg::CH_FREE;
            end
        end else begin
            r_state    <= n_state;
            r_pre_mid  <= n_pre_mid;
            r_pre_slow <= n_pre_slow;
            r_pend_v   <= n_pend_v;
            if (st_we) begin
                r_status[flat] <= st_wdata;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mrtb_pkg::REG_ENABLE: r_enable   <= i_cfg_data[0];
                    mrtb_pkg::REG_MID:    r_mid_div  <= i_cfg_data;
                    mrtb_pkg::REG_SLOW:   r_slow_div <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_bank      <= n_bank;
        r_loc       <= n_loc;
        r_sel       <= n_sel;
        r_pend_unit <= n_pend_unit;
        r_pend_ch   <= n_pend_ch;
        r_res       <= n_res;
        r_cmd       <= n_cmd;
        if (emit) begin
            r_o <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_count[flat] <= cnt_wdata;
        end
        if (rl_we) begin
            r_reload[flat] <= r_cmd.reload;
            r_cyc[flat]    <= r_cmd.cyclic;
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_o;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the multi-resolution timer bank.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    localparam int NCH = 24;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  unit;
        logic [7:0]  chan;
        logic [15:0] interval;
        logic        cyclic;
    } t_cmd_item;

    typedef struct packed {
        logic       ok;
        logic       fired;
        logic [6:0] unit;
        logic [2:0] chan;
        logic       last;
    } t_timer_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [5:0]  i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic [2:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic        o_m_tlast;

    multi_resolution_timer_bank dut (.*);

    // Predictor state.
    logic        en_q;
    logic [5:0]  mid_div_q, slow_div_q, pre_mid_q, pre_slow_q;
    logic [1:0]  status_q [NCH];
    logic [16:0] count_q [NCH];
    logic [16:0] reload_q [NCH];
    logic        cyc_q [NCH];

    t_cmd_item     pending_cmds[$];
    t_timer_result expected_results[$];
    int errors = 0;
    int cycles = 0;
    bit driver_hold = 0;

    // Handshake as seen at the last rising edge, for the driver's pop.
    logic o_s_tready_s = 1'b0;

    function automatic int bank_index(input logic [7:0] u);
        if (u == 8'd1) return 0;
        if (u == 8'd10) return 1;
        if (u == 8'd100) return 2;
        return -1;
    endfunction

    function automatic logic [6:0] unit_of(input int b);
        return (b == 0) ? 7'd1 : (b == 1) ? 7'd10 : 7'd100;
    endfunction

    function automatic t_timer_result mk(input logic ok, input logic f,
                                         input logic [6:0] u, input logic [2:0] c);
        t_timer_result r;
        r.ok = ok; r.fired = f; r.unit = u; r.chan = c; r.last = 1'b1;
        return r;
    endfunction

    task automatic count_down(input int b);
        for (int i = 0; i < 8; i++)
            if (status_q[b*8+i] == mrtb_pkg::CH_RUN && count_q[b*8+i] != 17'd0)
                count_q[b*8+i] = count_q[b*8+i] - 17'd1;
    endtask

    task automatic predict_timer(input t_cmd_item c);
        int b, x, n;
        logic [16:0] rl;
        t_timer_result r;
        b = bank_index(c.unit);
        x = (b >= 0 && c.chan < 8) ? b*8 + c.chan : -1;
        case (c.op)
            mrtb_pkg::OP_CREATE: begin
                r = mk(0, 0, 0, 0);
                if (b >= 0)
                    for (int i = 0; i < 8; i++)
                        if (r.ok == 0 && status_q[b*8+i] == mrtb_pkg::CH_FREE) begin
                            rl = 17'(c.interval / unit_of(b));
                            if (!c.cyclic) rl = rl + 17'd1;
                            status_q[b*8+i] = mrtb_pkg::CH_STOP;
                            cyc_q[b*8+i] = c.cyclic;
                            reload_q[b*8+i] = rl;
                            r = mk(1, 0, unit_of(b), 3'(i));
                        end
                expected_results.push_back(r);
            end
            mrtb_pkg::OP_DELETE: begin
                if (x >= 0) status_q[x] = mrtb_pkg::CH_FREE;
                expected_results.push_back(mk(x >= 0, 0, 0, 0));
            end
            mrtb_pkg::OP_START, mrtb_pkg::OP_STOP: begin
                if (x >= 0 && status_q[x] != mrtb_pkg::CH_FREE) begin
                    if (c.op == mrtb_pkg::OP_START) begin
                        status_q[x] = mrtb_pkg::CH_RUN;
                        count_q[x] = reload_q[x];
                    end else
                        status_q[x] = mrtb_pkg::CH_STOP;
                    expected_results.push_back(mk(1, 0, 0, 0));
                end else
                    expected_results.push_back(mk(0, 0, 0, 0));
            end
            mrtb_pkg::OP_TICK: begin
                if (en_q) begin
                    count_down(0);
                    if (7'(pre_mid_q) + 1 >= 7'(mid_div_q)) begin
                        count_down(1); pre_mid_q = 0;
                    end else pre_mid_q = pre_mid_q + 6'd1;
                    if (7'(pre_slow_q) + 1 >= 7'(slow_div_q)) begin
                        count_down(2); pre_slow_q = 0;
                    end else pre_slow_q = pre_slow_q + 6'd1;
                end
                expected_results.push_back(mk(en_q, 0, 0, 0));
            end
            mrtb_pkg::OP_CHECK: begin
                if (!en_q)
                    expected_results.push_back(mk(0, 0, 0, 0));
                else begin
                    n = 0;
                    for (int bk = 0; bk < 3; bk++)
                        for (int i = 7; i >= 0; i--)
                            if (status_q[bk*8+i] == mrtb_pkg::CH_RUN
                                && count_q[bk*8+i] == 17'd0) begin
                                r = mk(1, 1, unit_of(bk), 3'(i));
                                r.last = 1'b0;
                                expected_results.push_back(r);
                                n++;
                                if (cyc_q[bk*8+i]) count_q[bk*8+i] = reload_q[bk*8+i];
                            end
                    if (n == 0) expected_results.push_back(mk(1, 0, 0, 0));
                    else expected_results[$].last = 1'b1;
                end
            end
            default: expected_results.push_back(mk(0, 0, 0, 0));
        endcase
    endtask

    initial forever #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Driver: bursts of beats separated by random gaps.
    int burst = 0, gap = 0;
    always @(negedge i_clk) begin
        if (i_s_tvalid && o_s_tready_s) begin
            void'(pending_cmds.pop_front());
        end
        if (i_s_tvalid && !o_s_tready_s) begin
        end else if (driver_hold || !i_rst_n || pending_cmds.size() == 0) begin
            i_s_tvalid <= 1'b0;
        end else if (gap > 0) begin
            gap = gap - 1;
            i_s_tvalid <= 1'b0;
        end else begin
            if (burst == 0) burst = $urandom_range(1, 12);
            burst = burst - 1;
            if (burst == 0) gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            i_s_tvalid <= 1'b1;
            i_s_tuser <= pending_cmds[0].op;
            i_s_tdata <= {7'd0, pending_cmds[0].cyclic, pending_cmds[0].interval,
                          pending_cmds[0].chan, pending_cmds[0].unit};
        end
        case (($urandom_range(0, 1023) >> 7))
            0: i_m_tready <= 1'b0;
            1: i_m_tready <= $urandom_range(0, 1);
            default: i_m_tready <= 1'b1;
        endcase
    end

    t_cmd_item beat;
    t_timer_result got, want;
    always @(posedge i_clk) begin
        o_s_tready_s <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            beat.op = i_s_tuser;
            beat.unit = i_s_tdata[7:0];
            beat.chan = i_s_tdata[15:8];
            beat.interval = i_s_tdata[31:16];
            beat.cyclic = i_s_tdata[32];
            predict_timer(beat);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.ok = o_m_tdata[0];
            got.fired = o_m_tdata[1];
            got.unit = o_m_tdata[8:2];
            got.chan = o_m_tdata[11:9];
            got.last = o_m_tlast;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got != want || o_m_tdata[15:12] != 0) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp ok=%b f=%b u=%0d ch=%0d l=%b,",
                                  " got ok=%b f=%b u=%0d ch=%0d l=%b"},
                                 want.ok, want.fired, want.unit, want.chan, want.last,
                                 got.ok, got.fired, got.unit, got.chan, got.last);
                end
            end
        end
    end

    function automatic t_cmd_item rand_cmd(input bit noisy);
        t_cmd_item c;
        logic [7:0] units [3] = '{8'd1, 8'd10, 8'd100};
        c.op = (noisy && $urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                    : 3'($urandom_range(0, 5));
        c.unit = (noisy && $urandom_range(0, 4) == 0) ? 8'($urandom)
                                                      : units[$urandom_range(0, 2)];
        c.chan = (noisy && $urandom_range(0, 4) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0: c.interval = 16'($urandom);
            1: c.interval = 16'($urandom_range(0, 120));
            default: c.interval = 16'($urandom_range(0, 1200));
        endcase
        if (c.unit == 8'd100 && $urandom_range(0, 1)) c.interval = 16'($urandom_range(0, 600));
        c.cyclic = $urandom_range(0, 1);
        return c;
    endfunction

    function automatic t_cmd_item dc(input logic [2:0] op, input logic [7:0] u,
                                     input logic [7:0] ch, input logic [15:0] iv,
                                     input logic cy);
        t_cmd_item c;
        c.op = op; c.unit = u; c.chan = ch; c.interval = iv; c.cyclic = cy;
        return c;
    endfunction

    task automatic drain();
        while (pending_cmds.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == mrtb_pkg::REG_ENABLE) en_q = val[0];
        else if (idx == mrtb_pkg::REG_MID) mid_div_q = val;
        else slow_div_q = val;
    endtask

    task automatic run_random(input int n);
        for (int k = 0; k < n; k++) begin
            // Ticks, some followed by a check, mixed with random timer operations, some malformed.
            if ($urandom_range(0, 2) == 0) begin
                pending_cmds.push_back(dc(mrtb_pkg::OP_TICK, 0, 8'($urandom), 16'($urandom),
                                          $urandom_range(0, 1)));
                if ($urandom_range(0, 1))
                    pending_cmds.push_back(dc(mrtb_pkg::OP_CHECK, 0, 0, 0, 0));
            end else
                pending_cmds.push_back(rand_cmd($urandom_range(0, 3) == 0));
        end
    endtask

    initial begin
        en_q = 1; mid_div_q = 5; slow_div_q = 50; pre_mid_q = 0; pre_slow_q = 0;
        for (int i = 0; i < NCH; i++) begin
            status_q[i] = mrtb_pkg::CH_FREE; count_q[i] = 0; reload_q[i] = 0; cyc_q[i] = 0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        write_reg(mrtb_pkg::REG_MID, 6'd1);
        write_reg(mrtb_pkg::REG_SLOW, 6'd2);
        // Directed: extremes, every operation, failures and zero reload.
        pending_cmds.push_back(dc(mrtb_pkg::OP_CREATE, 8'd1, 0, 16'd65535, 1'b0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_CREATE, 8'd10, 0, 16'd5, 1'b1));
        pending_cmds.push_back(dc(mrtb_pkg::OP_CREATE, 8'd100, 0, 16'd0, 1'b0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_CREATE, 8'd255, 0, 16'd100, 1'b1));
        pending_cmds.push_back(dc(mrtb_pkg::OP_CREATE, 8'd1, 0, 16'd2, 1'b1));
        pending_cmds.push_back(dc(mrtb_pkg::OP_START, 8'd10, 0, 0, 0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_START, 8'd100, 0, 0, 0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_START, 8'd1, 1, 0, 0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_START, 8'd1, 8'd255, 0, 0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_START, 8'd1, 7, 0, 0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_CHECK, 0, 0, 0, 0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_TICK, 8'hFF, 8'hFF, 16'hFFFF, 1));
        pending_cmds.push_back(dc(mrtb_pkg::OP_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_CHECK, 0, 0, 0, 0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_CHECK, 0, 0, 0, 0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_STOP, 8'd10, 0, 0, 0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_STOP, 8'd10, 5, 0, 0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_DELETE, 8'd1, 7, 0, 0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_DELETE, 8'd100, 8, 0, 0));
        pending_cmds.push_back(dc(3'd6, 8'd1, 0, 0, 0));
        pending_cmds.push_back(dc(3'd7, 8'd10, 0, 0, 0));
        for (int i = 0; i < 8; i++)
            pending_cmds.push_back(dc(mrtb_pkg::OP_CREATE, 8'd1, 0, 16'd3, 1));
        drain();

        write_reg(mrtb_pkg::REG_ENABLE, 6'd0);
        pending_cmds.push_back(dc(mrtb_pkg::OP_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_CHECK, 0, 0, 0, 0));
        pending_cmds.push_back(dc(mrtb_pkg::OP_START, 8'd1, 2, 0, 0));
        drain();
        write_reg(mrtb_pkg::REG_ENABLE, 6'd1);
        write_reg(mrtb_pkg::REG_MID, 6'd5);
        write_reg(mrtb_pkg::REG_SLOW, 6'd50);
        run_random(70);
        drain();
        write_reg(mrtb_pkg::REG_MID, 6'd63);
        write_reg(mrtb_pkg::REG_SLOW, 6'd0);
        run_random(50);
        // Hold the sender until everything in flight has come back.
        while (pending_cmds.size() > 20) @(posedge i_clk);
        driver_hold = 1;
        while (i_s_tvalid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        driver_hold = 0;
        drain();
        write_reg(mrtb_pkg::REG_MID, 6'd3);
        write_reg(mrtb_pkg::REG_SLOW, 6'd1);
        run_random(50);
        drain();

        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
design/mrtb_pkg.sv
design/mrtb_front.sv
design/mrtb_queue.sv
design/mrtb_back.sv
design/multi_resolution_timer_bank.sv
tb/sv/testbench.sv
